@@ rtl/rlmc_pkg.sv @@
// ----------------------------------------------------------------------------
// rlmc_pkg
// Types, codes and constants shared by the RGB lamp mode controller.
// ----------------------------------------------------------------------------
`default_nettype none

package rlmc_pkg;

  localparam int HUE_DEGREES_DEFAULT = 360;
  localparam int COLOR_MAX_DEFAULT   = 255;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_COMMON_ANODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HUE_STEP_MS  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FLASH_ON_MS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FLASH_OFF_MS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BEAT_MS      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RANDOM_SEED  = 3'd5;

  // register reset values
  localparam logic [15:0] HUE_STEP_RESET  = 16'd20;
  localparam logic [15:0] FLASH_ON_RESET  = 16'd120;
  localparam logic [15:0] FLASH_OFF_RESET = 16'd120;
  localparam logic [15:0] BEAT_RESET      = 16'd500;
  localparam logic [15:0] SEED_RESET      = 16'd44257;

  // opcodes
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  // lamp modes
  localparam logic [2:0] MODE_WHITE = 3'd1;
  localparam logic [2:0] MODE_CYCLE = 3'd2;
  localparam logic [2:0] MODE_FLASH = 3'd3;
  localparam logic [2:0] MODE_PARTY = 3'd4;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAW,
    ST_DIV,
    ST_POST,
    ST_HUE_MUL,
    ST_FADE_A,
    ST_FADE_B,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    JOB_SECTOR,
    JOB_HUE_VAL,
    JOB_FADE
  } job_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    logic [15:0] r;
    r = {1'b0, s[15:1]};
    if (s[0]) begin
      r = r ^ LFSR_TAPS;
    end
    return r;
  endfunction

  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rlmc_channels.sv @@
// ----------------------------------------------------------------------------
// rlmc channels
// Valid/ready channel interfaces for lamp commands and lamp colors.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlmc_cmd_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [2:0] mode_value;

  modport source (output valid, output opcode, output mode_value, input ready);
  modport sink   (input valid, input opcode, input mode_value, output ready);
endinterface

interface rlmc_color_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [2:0] active_mode;
  logic       command_accepted;

  modport source (output valid, output red, output green, output blue,
                  output active_mode, output command_accepted, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input active_mode, input command_accepted, output ready);
endinterface

`default_nettype wire

@@ rtl/rgb_lamp_mode_controller.sv @@
// ----------------------------------------------------------------------------
// rgb_lamp_mode_controller
// Four-mode RGB lamp: steady white, hue cycle, flash, random color fade.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  cmd      in   valid/ready    opcode, mode_value
//  color    out  valid/ready    red, green, blue, active_mode, command_accepted
//  cfg      in   cfg_we         cfg_index, cfg_data
//
//  Hue steps and fade ticks run through the shared restoring divider and the
//  shared 16x8 multiplier. A fade tick that starts a new beat first draws new
//  targets, and a fade entry draws both start and target colors.
//  Reset is synchronous; no clearing pass. A new command is taken while the
//  last color waits; the result stage holds until color.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_lamp_mode_controller #(
  parameter int HUE_DEGREES = rlmc_pkg::HUE_DEGREES_DEFAULT,
  parameter int COLOR_MAX   = rlmc_pkg::COLOR_MAX_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [rlmc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rlmc_pkg::CFG_DATA_W-1:0]  cfg_data,
  rlmc_cmd_if.sink                              cmd,
  rlmc_color_if.source                          color
);

  localparam logic [15:0] HUE_W      = 16'(HUE_DEGREES / 6);
  localparam logic [8:0]  HUE_LAST   = 9'(HUE_DEGREES - 1);
  localparam logic [7:0]  CMAX       = 8'(COLOR_MAX);
  localparam logic [8:0]  RAND_SCALE = 9'(COLOR_MAX + 1);

  rlmc_pkg::state_t state, state_next;
  rlmc_pkg::job_t   job;

  logic        common_anode;
  logic [15:0] hue_step_ms, flash_on_ms, flash_off_ms, beat_ms;

  logic [2:0]  lamp_mode;
  logic [8:0]  hue_degrees;
  logic [15:0] tick_count;
  logic        flash_lit;
  logic [7:0]  present_color [3];
  logic [7:0]  beat_start    [3];
  logic [7:0]  beat_target   [3];
  logic [15:0] lfsr;

  logic [2:0]  div_cnt;
  logic [15:0] div_rem;
  logic [7:0]  div_low;
  logic [1:0]  chan;
  logic [2:0]  draw_idx;
  logic        fade_after;
  logic [23:0] acc;
  logic [15:0] mul_val;
  logic [2:0]  sector;
  logic        accepted;
  logic        out_valid;

  logic        accept, out_free, sel_valid;
  logic [15:0] step_eff, beat_eff, tick_inc, den;
  logic [16:0] trial;
  logic        trial_ge;
  logic [15:0] mul_a;
  logic [7:0]  mul_b;
  logic [23:0] prod, fade_sum;
  logic [15:0] lfsr_nx, rand_prod;
  logic [7:0]  rand_chan;
  logic [2:0]  tgt_idx;
  logic [7:0]  hue_x;

  assign accept    = cmd.valid && cmd.ready;
  assign out_free  = !out_valid || color.ready;
  assign sel_valid = (cmd.mode_value >= rlmc_pkg::MODE_WHITE) &&
                     (cmd.mode_value <= rlmc_pkg::MODE_PARTY);
  assign step_eff  = rlmc_pkg::at_least_one(hue_step_ms);
  assign beat_eff  = rlmc_pkg::at_least_one(beat_ms);
  assign tick_inc  = tick_count + 16'd1;

  // shared restoring divider, 8 quotient bits
  assign den      = (job == rlmc_pkg::JOB_FADE) ? beat_eff : HUE_W;
  assign trial    = {div_rem, div_low[7]};
  assign trial_ge = trial >= {1'b0, den};

  // shared multiplier
  always_comb begin
    unique case (state)
      rlmc_pkg::ST_FADE_A: begin
        mul_a = beat_eff - tick_count;
        mul_b = beat_start[chan];
      end
      rlmc_pkg::ST_FADE_B: begin
        mul_a = tick_count;
        mul_b = beat_target[chan];
      end
      default: begin
        mul_a = mul_val;
        mul_b = CMAX;
      end
    endcase
  end

  assign prod     = 24'(mul_a) * 24'(mul_b);
  assign fade_sum = acc + prod;

  assign lfsr_nx   = rlmc_pkg::lfsr_step(lfsr);
  assign rand_prod = 16'(lfsr_nx[7:0]) * 16'(RAND_SCALE);
  assign rand_chan = rand_prod[15:8];
  assign tgt_idx   = draw_idx - 3'd3;
  assign hue_x     = div_low;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rlmc_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd.opcode == rlmc_pkg::OP_TICK) begin
            if (lamp_mode == rlmc_pkg::MODE_CYCLE && tick_inc >= step_eff) begin
              state_next = rlmc_pkg::ST_DIV;
            end else if (lamp_mode == rlmc_pkg::MODE_PARTY) begin
              state_next = (tick_inc >= beat_eff) ? rlmc_pkg::ST_DRAW
                                                  : rlmc_pkg::ST_FADE_A;
            end else begin
              state_next = rlmc_pkg::ST_DONE;
            end
          end else if (sel_valid && cmd.mode_value != lamp_mode &&
                       cmd.mode_value == rlmc_pkg::MODE_PARTY) begin
            state_next = rlmc_pkg::ST_DRAW;
          end else begin
            state_next = rlmc_pkg::ST_DONE;
          end
        end
      end
      rlmc_pkg::ST_DRAW: begin
        if (draw_idx == 3'd5) begin
          state_next = fade_after ? rlmc_pkg::ST_FADE_A : rlmc_pkg::ST_DONE;
        end
      end
      rlmc_pkg::ST_DIV: begin
        if (div_cnt == 3'd7) begin
          state_next = rlmc_pkg::ST_POST;
        end
      end
      rlmc_pkg::ST_POST: begin
        unique case (job)
          rlmc_pkg::JOB_SECTOR:  state_next = rlmc_pkg::ST_HUE_MUL;
          rlmc_pkg::JOB_HUE_VAL: state_next = rlmc_pkg::ST_DONE;
          default: state_next = (chan == 2'd2) ? rlmc_pkg::ST_DONE
                                               : rlmc_pkg::ST_FADE_A;
        endcase
      end
      rlmc_pkg::ST_HUE_MUL: state_next = rlmc_pkg::ST_DIV;
      rlmc_pkg::ST_FADE_A:  state_next = rlmc_pkg::ST_FADE_B;
      rlmc_pkg::ST_FADE_B:  state_next = rlmc_pkg::ST_DIV;
      rlmc_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = rlmc_pkg::ST_IDLE;
        end
      end
      default: state_next = rlmc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.ready = (state == rlmc_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rlmc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      common_anode  <= 1'b0;
      hue_step_ms   <= rlmc_pkg::HUE_STEP_RESET;
      flash_on_ms   <= rlmc_pkg::FLASH_ON_RESET;
      flash_off_ms  <= rlmc_pkg::FLASH_OFF_RESET;
      beat_ms       <= rlmc_pkg::BEAT_RESET;
      lfsr          <= rlmc_pkg::SEED_RESET;
      lamp_mode     <= rlmc_pkg::MODE_WHITE;
      hue_degrees   <= '0;
      tick_count    <= '0;
      flash_lit     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        present_color[i] <= CMAX;
        beat_start[i]    <= '0;
        beat_target[i]   <= '0;
      end
      job           <= rlmc_pkg::JOB_SECTOR;
      div_cnt       <= '0;
      chan          <= '0;
      draw_idx      <= '0;
      fade_after    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rlmc_pkg::REG_COMMON_ANODE: common_anode <= cfg_data[0];
          rlmc_pkg::REG_HUE_STEP_MS:  hue_step_ms  <= cfg_data;
          rlmc_pkg::REG_FLASH_ON_MS:  flash_on_ms  <= cfg_data;
          rlmc_pkg::REG_FLASH_OFF_MS: flash_off_ms <= cfg_data;
          rlmc_pkg::REG_BEAT_MS:      beat_ms      <= cfg_data;
          rlmc_pkg::REG_RANDOM_SEED:  lfsr <= rlmc_pkg::at_least_one(cfg_data);
          default: ;
        endcase
      end

      unique case (state)
        rlmc_pkg::ST_IDLE: begin
          if (accept) begin
            accepted <= (cmd.opcode == rlmc_pkg::OP_SELECT) && sel_valid;
            chan     <= '0;
            div_cnt  <= '0;
            if (cmd.opcode == rlmc_pkg::OP_TICK) begin
              unique case (lamp_mode)
                rlmc_pkg::MODE_CYCLE: begin
                  if (tick_inc >= step_eff) begin
                    tick_count <= '0;
                    job        <= rlmc_pkg::JOB_SECTOR;
                    div_rem    <= {15'd0, hue_degrees[8]};
                    div_low    <= hue_degrees[7:0];
                  end else begin
                    tick_count <= tick_inc;
                  end
                end
                rlmc_pkg::MODE_FLASH: begin
                  if (tick_count == 16'd0) begin
                    flash_lit <= !flash_lit;
                    for (int i = 0; i < 3; i++) begin
                      present_color[i] <= flash_lit ? 8'd0 : CMAX;
                    end
                    tick_count <= (flash_lit ? rlmc_pkg::at_least_one(flash_off_ms)
                                             : rlmc_pkg::at_least_one(flash_on_ms))
                                  - 16'd1;
                  end else begin
                    tick_count <= tick_count - 16'd1;
                  end
                end
                rlmc_pkg::MODE_PARTY: begin
                  if (tick_inc >= beat_eff) begin
                    for (int i = 0; i < 3; i++) begin
                      beat_start[i] <= beat_target[i];
                    end
                    tick_count <= '0;
                    draw_idx   <= 3'd3;
                    fade_after <= 1'b1;
                  end else begin
                    tick_count <= tick_inc;
                  end
                end
                default: begin
                  for (int i = 0; i < 3; i++) begin
                    present_color[i] <= CMAX;
                  end
                end
              endcase
            end else if (sel_valid && cmd.mode_value != lamp_mode) begin
              lamp_mode  <= cmd.mode_value;
              tick_count <= '0;
              unique case (cmd.mode_value)
                rlmc_pkg::MODE_WHITE: begin
                  for (int i = 0; i < 3; i++) begin
                    present_color[i] <= CMAX;
                  end
                end
                rlmc_pkg::MODE_CYCLE: hue_degrees <= '0;
                rlmc_pkg::MODE_FLASH: flash_lit <= 1'b0;
                default: begin
                  draw_idx   <= 3'd0;
                  fade_after <= 1'b0;
                end
              endcase
            end
          end
        end
        rlmc_pkg::ST_DRAW: begin
          lfsr     <= lfsr_nx;
          draw_idx <= draw_idx + 3'd1;
          if (draw_idx < 3'd3) begin
            beat_start[draw_idx[1:0]] <= rand_chan;
          end else begin
            beat_target[tgt_idx[1:0]] <= rand_chan;
          end
        end
        rlmc_pkg::ST_DIV: begin
          div_cnt <= div_cnt + 3'd1;
          div_rem <= trial_ge ? 16'(trial - {1'b0, den}) : trial[15:0];
          div_low <= {div_low[6:0], trial_ge};
        end
        rlmc_pkg::ST_POST: begin
          unique case (job)
            rlmc_pkg::JOB_SECTOR: begin
              // past the last sector: hold at the end of sector 5
              if (div_low > 8'd5) begin
                sector  <= 3'd5;
                mul_val <= 16'd0;
              end else begin
                sector  <= div_low[2:0];
                mul_val <= div_low[0] ? (HUE_W - div_rem) : div_rem;
              end
            end
            rlmc_pkg::JOB_HUE_VAL: begin
              unique case (sector)
                3'd0: begin
                  present_color[0] <= CMAX;  present_color[1] <= hue_x;
                  present_color[2] <= 8'd0;
                end
                3'd1: begin
                  present_color[0] <= hue_x; present_color[1] <= CMAX;
                  present_color[2] <= 8'd0;
                end
                3'd2: begin
                  present_color[0] <= 8'd0;  present_color[1] <= CMAX;
                  present_color[2] <= hue_x;
                end
                3'd3: begin
                  present_color[0] <= 8'd0;  present_color[1] <= hue_x;
                  present_color[2] <= CMAX;
                end
                3'd4: begin
                  present_color[0] <= hue_x; present_color[1] <= 8'd0;
                  present_color[2] <= CMAX;
                end
                default: begin
                  present_color[0] <= CMAX;  present_color[1] <= 8'd0;
                  present_color[2] <= hue_x;
                end
              endcase
              hue_degrees <= (hue_degrees >= HUE_LAST) ? 9'd0 : hue_degrees + 9'd1;
            end
            default: begin
              present_color[chan] <= div_low;
              chan <= chan + 2'd1;
            end
          endcase
        end
        rlmc_pkg::ST_HUE_MUL: begin
          job     <= rlmc_pkg::JOB_HUE_VAL;
          div_cnt <= '0;
          div_rem <= prod[23:8];
          div_low <= prod[7:0];
        end
        rlmc_pkg::ST_FADE_A: begin
          acc <= prod;
        end
        rlmc_pkg::ST_FADE_B: begin
          job     <= rlmc_pkg::JOB_FADE;
          div_cnt <= '0;
          div_rem <= fade_sum[23:8];
          div_low <= fade_sum[7:0];
        end
        default: ;
      endcase

      if (state == rlmc_pkg::ST_DONE && out_free) begin
        out_valid              <= 1'b1;
        color.red              <= common_anode ? CMAX - present_color[0] : present_color[0];
        color.green            <= common_anode ? CMAX - present_color[1] : present_color[1];
        color.blue             <= common_anode ? CMAX - present_color[2] : present_color[2];
        color.active_mode      <= lamp_mode;
        color.command_accepted <= accepted;
      end else if (color.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign color.valid = out_valid;

endmodule

`default_nettype wire

@@ rtl/rlmc_checker.sv @@
// ----------------------------------------------------------------------------
// rlmc_checker
// Port-level checks for the RGB lamp mode controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rlmc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       cmd_valid,
  input wire logic       cmd_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue,
  input wire logic [2:0] out_mode
);

  // a stalled transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("color transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_red) && $stable(out_green) &&
                                $stable(out_blue) && $stable(out_mode))
    else $error("color payload changed while stalled");

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_mode == 3'd1 || out_mode == 3'd2 ||
                   out_mode == 3'd3 || out_mode == 3'd4))
    else $error("active mode out of range");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while previous one in progress");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("color valid after reset");

endmodule

bind rgb_lamp_mode_controller rlmc_checker u_rlmc_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .out_valid (color.valid),
  .out_ready (color.ready),
  .out_red   (color.red),
  .out_green (color.green),
  .out_blue  (color.blue),
  .out_mode  (color.active_mode)
);

`default_nettype wire
